// ----- src/link_latency_iqr_inspector_unit_macros.svh -----
// ----------------------------------------------------------------------------
// link latency iqr inspector assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LINK_LATENCY_IQR_INSPECTOR_UNIT_MACROS_SVH
`define LINK_LATENCY_IQR_INSPECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LLIQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LLIQR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LLIQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LLIQR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/lliqr_pkg.sv -----
// ----------------------------------------------------------------------------
// link latency iqr inspector package
// field widths, register indexes and sequencer states
// ----------------------------------------------------------------------------
package lliqr_pkg;

	localparam int LAT_W   = 20;
	localparam int RTT_W   = 20;
	localparam int SWIDX_W = 2;
	localparam int RES_W   = 22;
	localparam int TH_W    = 23;
	localparam int MULT_W  = 3;
	localparam int CFG_W   = 22;
	localparam int CFG_A_W = 2;

	localparam logic [RTT_W-1:0]   PREFILL_US        = RTT_W'(1000);
	localparam logic [CFG_W-1:0]   FALLBACK_RESET    = CFG_W'(10000);
	localparam logic [RTT_W-1:0]   LIMIT_RESET       = RTT_W'(50000);
	localparam logic [MULT_W-1:0]  MULT_RESET        = MULT_W'(3);

	localparam logic [CFG_A_W-1:0] CFG_FALLBACK_THRESHOLD = 2'd0;
	localparam logic [CFG_A_W-1:0] CFG_PROBE_TIME_LIMIT   = 2'd1;
	localparam logic [CFG_A_W-1:0] CFG_FENCE_MULTIPLIER   = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH1,
		ST_PUSH2,
		ST_CAND,
		ST_CAND_WAIT,
		ST_SCAN,
		ST_FENCE
	} state_t;

endpackage

// ----- src/lliqr_ram.sv -----
// ----------------------------------------------------------------------------
// lliqr generic ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module lliqr_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/link_latency_iqr_inspector_unit.sv -----
// ----------------------------------------------------------------------------
// link latency iqr inspector
// per-switch sliding windows of probe round-trip times, an interquartile
// fence from the ingress window, and residual alarms for each link event
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  cfg      cfg_we                cfg_addr, cfg_wdata
//  in       in_valid / in_ready   link_latency, switches, probe rtts
//  out      out_valid / out_ready link_residual, fence_threshold, alarms
//
//  a result is valid in the same cycle that in_ready is back, and the block
//  takes no new transaction until the result of the previous one has been
//  loaded into the output register
//  the rank search runs one shared comparator over the window ram, one read
//  per cycle: each candidate is fetched, then compared against every entry
//  after reset every ram entry is filled with 1000 us before in_ready rises
//  a result waits in the output register; only the next result stalls on it
// ----------------------------------------------------------------------------
`include "link_latency_iqr_inspector_unit_macros.svh"

module link_latency_iqr_inspector_unit import lliqr_pkg::*; #(
	parameter int HISTORY_DEPTH = 20,
	parameter int NUM_SWITCHES  = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_A_W-1:0]       cfg_addr,
	input  logic [CFG_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [LAT_W-1:0]         link_latency,
	input  logic [SWIDX_W-1:0]       first_switch,
	input  logic [SWIDX_W-1:0]       second_switch,
	input  logic [RTT_W-1:0]         first_probe_rtt,
	input  logic [RTT_W-1:0]         second_probe_rtt,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [RES_W-1:0] link_residual,
	output logic [TH_W-1:0]          fence_threshold,
	output logic                     fence_alarm,
	output logic                     residual_alarm
);

	localparam int DEPTH_TOTAL = NUM_SWITCHES * HISTORY_DEPTH;
	localparam int AW          = $clog2(DEPTH_TOTAL);
	localparam int SLW         = $clog2(HISTORY_DEPTH);
	localparam int CW          = $clog2(HISTORY_DEPTH + 1);
	localparam int WW          = $clog2(NUM_SWITCHES);
	localparam int LAST_WIN    = NUM_SWITCHES - 1;
	localparam int K1          = HISTORY_DEPTH / 4;
	localparam int K3          = (3 * HISTORY_DEPTH) / 4;

	state_t state_q, state_d;

	logic [AW-1:0]     clr_q;
	logic [SLW-1:0]    heads_q [NUM_SWITCHES];
	logic [CFG_W-1:0]  fallback_q;
	logic [RTT_W-1:0]  limit_q;
	logic [MULT_W-1:0] mult_q;

	logic [LAT_W-1:0]  lat_q;
	logic [RTT_W-1:0]  rtt1_q, rtt2_q;
	logic [WW-1:0]     win1_q, win2_q;
	logic [CW-1:0]     cand_q, scan_q;
	logic [RTT_W-1:0]  cand_val_q;
	logic [CW-1:0]     less_q, le_q;
	logic [RTT_W-1:0]  q1_q, q3_q;
	logic              found1_q, found3_q;

	logic                    out_valid_q;
	logic signed [RES_W-1:0] res_q;
	logic [TH_W-1:0]         th_q;
	logic                    fence_al_q, resid_al_q;

	logic [WW-1:0]    win1_map, win2_map, win_sel;
	logic [SLW-1:0]   head_cur, head_nxt, rd_slot;
	logic [AW-1:0]    win_base;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [RTT_W-1:0] ram_wdata, ram_rdata;

	logic             lt, le, last_cmp, hit1, hit3;
	logic [CW-1:0]    less_nx, le_nx;
	logic             out_load;

	logic [RTT_W-1:0]        iqr;
	logic [TH_W-1:0]         th;
	logic signed [RES_W-1:0] resid;
	logic signed [TH_W:0]    resid_x, th_x;

	lliqr_ram #(
		.WIDTH(RTT_W),
		.DEPTH(DEPTH_TOTAL)
	) u_win_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// index at or above the last switch maps to the last window
	assign win1_map = (32'(first_switch) >= LAST_WIN) ? WW'(LAST_WIN) : WW'(first_switch);
	assign win2_map = (32'(second_switch) >= LAST_WIN) ? WW'(LAST_WIN) : WW'(second_switch);

	assign win_sel  = (state_q == ST_PUSH2) ? win2_q : win1_q;
	assign head_cur = heads_q[win_sel];
	assign head_nxt = (head_cur == SLW'(HISTORY_DEPTH - 1)) ? '0 : head_cur + 1'b1;
	assign win_base = AW'(win_sel) * AW'(HISTORY_DEPTH);

	always_comb begin
		if (state_q == ST_CAND) begin
			rd_slot = cand_q[SLW-1:0];
		end else if (scan_q == CW'(HISTORY_DEPTH)) begin
			rd_slot = '0;
		end else begin
			rd_slot = scan_q[SLW-1:0];
		end
	end

	// shared rank comparator
	assign lt       = ram_rdata < cand_val_q;
	assign le       = ram_rdata <= cand_val_q;
	assign less_nx  = less_q + CW'(lt);
	assign le_nx    = le_q + CW'(le);
	assign last_cmp = scan_q == CW'(HISTORY_DEPTH);
	assign hit1     = (less_nx <= CW'(K1)) && (CW'(K1) < le_nx);
	assign hit3     = (less_nx <= CW'(K3)) && (CW'(K3) < le_nx);

	// fence and residual, windows shorter than four samples use the fallback
	assign iqr     = q3_q - q1_q;
	assign th      = (HISTORY_DEPTH < 4) ? TH_W'(fallback_q)
		: TH_W'(q3_q) + TH_W'(mult_q) * TH_W'(iqr);
	assign resid   = RES_W'(lat_q) - RES_W'(rtt1_q) - RES_W'(rtt2_q);
	assign resid_x = (TH_W+1)'(resid);
	assign th_x    = $signed({1'b0, th});

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH_TOTAL - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PUSH1;
				end
			end
			ST_PUSH1:     state_d = ST_PUSH2;
			ST_PUSH2:     state_d = ST_CAND;
			ST_CAND:      state_d = ST_CAND_WAIT;
			ST_CAND_WAIT: state_d = ST_SCAN;
			ST_SCAN: begin
				if (last_cmp) begin
					state_d = (cand_q == CW'(HISTORY_DEPTH - 1)) ? ST_FENCE : ST_CAND;
				end
			end
			ST_FENCE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = win_base + AW'(head_cur);
		ram_wdata = rtt1_q;
		ram_raddr = win_base + AW'(rd_slot);
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = PREFILL_US;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_PUSH1: begin
				ram_we = 1'b1;
			end
			ST_PUSH2: begin
				ram_we    = 1'b1;
				ram_wdata = rtt2_q;
			end
			ST_FENCE: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			fallback_q  <= FALLBACK_RESET;
			limit_q     <= LIMIT_RESET;
			mult_q      <= MULT_RESET;
			out_valid_q <= 1'b0;
			found1_q    <= 1'b0;
			found3_q    <= 1'b0;
			for (int s = 0; s < NUM_SWITCHES; s++) begin
				heads_q[s] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				case (cfg_addr)
					CFG_FALLBACK_THRESHOLD: fallback_q <= cfg_wdata;
					CFG_PROBE_TIME_LIMIT:   limit_q    <= cfg_wdata[RTT_W-1:0];
					CFG_FENCE_MULTIPLIER:   mult_q     <= cfg_wdata[MULT_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_PUSH1 || state_q == ST_PUSH2) begin
				heads_q[win_sel] <= head_nxt;
			end
			if (state_q == ST_PUSH1) begin
				found1_q <= 1'b0;
				found3_q <= 1'b0;
			end
			if (state_q == ST_SCAN && last_cmp) begin
				if (hit1) begin
					found1_q <= 1'b1;
				end
				if (hit3) begin
					found3_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lat_q  <= link_latency;
			rtt1_q <= first_probe_rtt;
			rtt2_q <= second_probe_rtt;
			win1_q <= win1_map;
			win2_q <= win2_map;
			cand_q <= '0;
		end
		case (state_q)
			ST_CAND: begin
				scan_q <= '0;
				less_q <= '0;
				le_q   <= '0;
			end
			ST_CAND_WAIT: begin
				cand_val_q <= ram_rdata;
				scan_q     <= CW'(1);
			end
			ST_SCAN: begin
				less_q <= less_nx;
				le_q   <= le_nx;
				if (last_cmp) begin
					cand_q <= cand_q + 1'b1;
					if (hit1) begin
						q1_q <= cand_val_q;
					end
					if (hit3) begin
						q3_q <= cand_val_q;
					end
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			res_q      <= resid;
			th_q       <= th;
			fence_al_q <= resid_x > th_x;
			resid_al_q <= resid[RES_W-1] || (rtt1_q > limit_q) || (rtt2_q > limit_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign link_residual   = res_q;
	assign fence_threshold = th_q;
	assign fence_alarm     = fence_al_q;
	assign residual_alarm  = resid_al_q;

	`LLIQR_ASSERT_IMP(a_quartiles_found, clk, arst_n, state_q == ST_FENCE, found1_q && found3_q, "quartile rank not found")
	`LLIQR_ASSERT_IMP(a_quartile_order, clk, arst_n, state_q == ST_FENCE, q1_q <= q3_q, "q1 above q3")
	`LLIQR_ASSERT_IMP(a_head_range, clk, arst_n, state_q == ST_PUSH1 || state_q == ST_PUSH2, {1'b0, head_cur} < (SLW+1)'(HISTORY_DEPTH), "window head out of range")
	`LLIQR_ASSERT_NXT(a_result_loaded, clk, arst_n, state_q == ST_FENCE && !out_valid_q, out_valid_q && state_q == ST_IDLE, "result not loaded")

endmodule

// ----- tb/link_latency_iqr_inspector_unit_tb.sv -----
// ----------------------------------------------------------------------------
// link latency iqr inspector testbench
// drives link events through the valid/ready input with random gaps, stalls
// the result side at random, and compares every result with a scoreboard that
// keeps its own per-switch probe windows and interquartile fence
// ----------------------------------------------------------------------------
module link_latency_iqr_inspector_unit_tb;
	import lliqr_pkg::*;

	localparam int DEPTH            = 20;
	localparam int NSW              = 4;
	localparam int EVENTS_PER_PHASE = 250;
	localparam int DRAIN_CYCLES     = 500;
	localparam int IDLE_GUARD       = 4;

	typedef struct {
		logic [LAT_W-1:0]   latency;
		logic [SWIDX_W-1:0] s1;
		logic [SWIDX_W-1:0] s2;
		logic [RTT_W-1:0]   p1;
		logic [RTT_W-1:0]   p2;
	} link_event_t;

	typedef struct {
		logic signed [RES_W-1:0] residual;
		logic [TH_W-1:0]         threshold;
		logic                    fence_al;
		logic                    resid_al;
	} link_verdict_t;

	class fence_scoreboard;
		logic [RTT_W-1:0]  windows [NSW][DEPTH];
		int unsigned       heads [NSW];
		int unsigned       counts [NSW];
		logic [CFG_W-1:0]  fallback;
		logic [RTT_W-1:0]  limit;
		logic [MULT_W-1:0] mult;
		link_verdict_t     awaited [$];
		int                errors;
		int                events;
		int                fence_hits;
		int                resid_hits;

		function new();
			for (int s = 0; s < NSW; s++) begin
				for (int k = 0; k < DEPTH; k++)
					windows[s][k] = PREFILL_US;
				heads[s] = 0;
				counts[s] = DEPTH;
			end
			fallback = FALLBACK_RESET;
			limit = LIMIT_RESET;
			mult = MULT_RESET;
			errors = 0;
			events = 0;
			fence_hits = 0;
			resid_hits = 0;
		endfunction

		function void set_register(logic [CFG_A_W-1:0] addr, logic [CFG_W-1:0] data);
			case (addr)
				CFG_FALLBACK_THRESHOLD: fallback = data;
				CFG_PROBE_TIME_LIMIT: limit = data[RTT_W-1:0];
				CFG_FENCE_MULTIPLIER: mult = data[MULT_W-1:0];
				default: ;
			endcase
		endfunction

		// indexes at or above the last switch share the last window
		function int unsigned window_of(logic [SWIDX_W-1:0] idx);
			return (int'(idx) >= NSW - 1) ? NSW - 1 : int'(idx);
		endfunction

		function void push_probe(int unsigned w, logic [RTT_W-1:0] v);
			int unsigned head;
			head = heads[w] % DEPTH;
			if (counts[w] < DEPTH) begin
				windows[w][(head + counts[w]) % DEPTH] = v;
				counts[w]++;
			end else begin
				windows[w][head] = v;
				heads[w] = (head + 1) % DEPTH;
			end
		endfunction

		function logic [TH_W-1:0] upper_fence(int unsigned w);
			int unsigned ranked [$];
			int unsigned n;
			int unsigned head;
			int unsigned q1;
			int unsigned q3;
			n = counts[w];
			if (n > DEPTH)
				n = DEPTH;
			head = heads[w] % DEPTH;
			if (n < 4)
				return TH_W'(fallback);
			for (int unsigned i = 0; i < n; i++)
				ranked = {ranked, int'(windows[w][(head + i) % DEPTH])};
			ranked.sort();
			q1 = ranked[n / 4];
			q3 = ranked[(3 * n) / 4];
			return TH_W'(q3 + int'(mult) * (q3 - q1));
		endfunction

		function void note_event(link_event_t ev);
			link_verdict_t v;
			int unsigned   w1;
			int unsigned   w2;
			longint        diff;
			w1 = window_of(ev.s1);
			w2 = window_of(ev.s2);
			push_probe(w1, ev.p1);
			push_probe(w2, ev.p2);
			diff = longint'(ev.latency) - longint'(ev.p1) - longint'(ev.p2);
			v.residual = RES_W'(diff);
			v.threshold = upper_fence(w1);
			v.fence_al = diff > longint'(v.threshold);
			v.resid_al = (diff < 0) || (ev.p1 > limit) || (ev.p2 > limit);
			awaited = {awaited, v};
			events++;
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(link_verdict_t got);
			link_verdict_t want;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, residual %0d",
					got.residual));
				return;
			end
			want = awaited[0];
			awaited.delete(0);
			if (got.residual !== want.residual)
				report_mismatch($sformatf("link_residual %0d, expected %0d",
					got.residual, want.residual));
			if (got.threshold !== want.threshold)
				report_mismatch($sformatf("fence_threshold %0d, expected %0d",
					got.threshold, want.threshold));
			if (got.fence_al !== want.fence_al)
				report_mismatch($sformatf("fence_alarm %b, expected %b",
					got.fence_al, want.fence_al));
			if (got.resid_al !== want.resid_al)
				report_mismatch($sformatf("residual_alarm %b, expected %b",
					got.resid_al, want.resid_al));
			fence_hits += int'(want.fence_al);
			resid_hits += int'(want.resid_al);
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_A_W-1:0]      cfg_addr;
	logic [CFG_W-1:0]        cfg_wdata;
	logic                    in_valid;
	logic                    in_ready;
	logic [LAT_W-1:0]        link_latency;
	logic [SWIDX_W-1:0]      first_switch;
	logic [SWIDX_W-1:0]      second_switch;
	logic [RTT_W-1:0]        first_probe_rtt;
	logic [RTT_W-1:0]        second_probe_rtt;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [RES_W-1:0] link_residual;
	logic [TH_W-1:0]         fence_threshold;
	logic                    fence_alarm;
	logic                    residual_alarm;

	fence_scoreboard sb;
	bit              calm;

	link_latency_iqr_inspector_unit #(
		.HISTORY_DEPTH(DEPTH),
		.NUM_SWITCHES (NSW)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.link_latency    (link_latency),
		.first_switch    (first_switch),
		.second_switch   (second_switch),
		.first_probe_rtt (first_probe_rtt),
		.second_probe_rtt(second_probe_rtt),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.link_residual   (link_residual),
		.fence_threshold (fence_threshold),
		.fence_alarm     (fence_alarm),
		.residual_alarm  (residual_alarm)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic link_event_t mk_event(int lat, int s1, int s2, int p1, int p2);
		link_event_t ev;
		ev.latency = LAT_W'(lat);
		ev.s1 = SWIDX_W'(s1);
		ev.s2 = SWIDX_W'(s2);
		ev.p1 = RTT_W'(p1);
		ev.p2 = RTT_W'(p2);
		return ev;
	endfunction

	function automatic logic [RTT_W-1:0] random_rtt();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return RTT_W'($urandom_range(400, 3000));
		if (pick < 85)
			return RTT_W'(int'(sb.limit) + int'($urandom_range(0, 4)) - 2);
		return RTT_W'($urandom);
	endfunction

	function automatic link_event_t random_event();
		link_event_t ev;
		int unsigned pick;
		int          total;
		ev.s1 = SWIDX_W'($urandom_range(0, 3));
		ev.s2 = SWIDX_W'($urandom_range(0, 3));
		ev.p1 = random_rtt();
		ev.p2 = random_rtt();
		total = int'(ev.p1) + int'(ev.p2);
		pick = $urandom_range(0, 99);
		if (pick < 60)
			ev.latency = LAT_W'(total + int'($urandom_range(0, 8000)));
		else if (pick < 80)
			ev.latency = LAT_W'(total - int'($urandom_range(0, 200)));
		else
			ev.latency = LAT_W'($urandom);
		return ev;
	endfunction

	// valid stays high across back-to-back transactions
	task automatic send_event(link_event_t ev);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		link_latency <= ev.latency;
		first_switch <= ev.s1;
		second_switch <= ev.s2;
		first_probe_rtt <= ev.p1;
		second_probe_rtt <= ev.p2;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_event(ev);
	endtask

	task automatic write_settings(int fb, int lim, int mult);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_FALLBACK_THRESHOLD;
		cfg_wdata <= CFG_W'(fb);
		sb.set_register(CFG_FALLBACK_THRESHOLD, CFG_W'(fb));
		@(posedge clk);
		cfg_addr <= CFG_PROBE_TIME_LIMIT;
		cfg_wdata <= CFG_W'(lim);
		sb.set_register(CFG_PROBE_TIME_LIMIT, CFG_W'(lim));
		@(posedge clk);
		cfg_addr <= CFG_FENCE_MULTIPLIER;
		cfg_wdata <= CFG_W'(mult);
		sb.set_register(CFG_FENCE_MULTIPLIER, CFG_W'(mult));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
	endtask

	initial begin : result_sink
		int unsigned   stall_left;
		link_verdict_t got;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				got.residual = link_residual;
				got.threshold = fence_threshold;
				got.fence_al = fence_alarm;
				got.resid_al = residual_alarm;
				sb.check_result(got);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		link_event_t plan [$];
		sb = new();
		calm = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= CFG_FALLBACK_THRESHOLD;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		link_latency <= '0;
		first_switch <= '0;
		second_switch <= '0;
		first_probe_rtt <= '0;
		second_probe_rtt <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// window ram clearing pass
		do @(posedge clk); while (in_ready !== 1'b1);

		// field extremes, alarm edges, same switch twice, every switch pair
		plan = {plan, mk_event(0, 0, 0, 0, 0)};
		plan = {plan, mk_event(1048575, 3, 3, 1048575, 1048575)};
		plan = {plan, mk_event(1048575, 0, 1, 0, 0)};
		plan = {plan, mk_event(0, 1, 2, 1048575, 1048575)};
		plan = {plan, mk_event(200000, 2, 3, 50000, 50000)};
		plan = {plan, mk_event(200000, 2, 3, 50001, 1000)};
		plan = {plan, mk_event(200000, 3, 2, 1000, 50001)};
		plan = {plan, mk_event(2000, 1, 1, 1000, 1000)};
		plan = {plan, mk_event(1999, 2, 2, 1000, 1000)};
		for (int a = 0; a < 4; a++)
			for (int b = 0; b < 4; b++)
				plan = {plan, mk_event($urandom_range(1500, 12000), a, b,
					$urandom_range(500, 3000), $urandom_range(500, 3000))};
		foreach (plan[i])
			send_event(plan[i]);
		settle();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_settings(0, 0, 0);
				1: write_settings(4000000, 1000000, 7);
				2: write_settings(22'h3FFFFF, 22'h3FFFFF, 7);
				3: write_settings($urandom_range(0, 4000000), $urandom_range(0, 1000000),
					$urandom_range(0, 7));
				default: write_settings(10000, 50000, 3);
			endcase
			calm = (phase == 4);
			repeat (EVENTS_PER_PHASE)
				send_event(random_event());
			settle();
		end
		calm = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		foreach (sb.awaited[i])
			sb.report_mismatch($sformatf("result never arrived, residual %0d",
				sb.awaited[i].residual));
		$display("covered %0d link events over reset values and five register settings",
			sb.events);
		$display("expected %0d fence alarms and %0d residual alarms",
			sb.fence_hits, sb.resid_hits);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
